/* rtl/core/mie_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

    // Reset value of the modulus register (prime 10^9 + 7)
    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture a new item, start the recurrence
        logic div_step;  // one quotient bit plus one multiply-mod step
        logic update;    // close a round: shift remainder and coefficient pairs
        logic store;     // copy the coefficient into the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic b_zero;    // divisor of the next round is zero: recurrence done
    } t_status;

endpackage

`default_nettype wire

/* rtl/core/modular_inverse_euclid.sv */
`timescale 1ns / 1ps
`default_nettype none

// Modular inverse by the extended Euclidean algorithm. Each item carries a
// value a; the result item is the Bezout coefficient u of a against the
// modulus m, reduced into 0..m-1 (u*a = gcd(a,m) mod m; no flag is raised
// when a and m share a factor, a zero value gives zero, and a modulus of
// zero or one gives zero). One item is in work at a time. Each Euclid round
// runs a one-bit-per-cycle restoring divider, which also drives a
// double-and-add multiply-mod of the quotient, then closes the round and
// tests the divisor; at 32 bits the worst case is about 47 rounds. The next
// item is taken while the previous result waits in the output register.
// The modulus is written through i_cfg_wr_en and i_cfg_wr_data and resets
// to 1000000007; the user must write it only while the block is idle, and
// the block itself does not enforce this.
module modular_inverse_euclid #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_value_valid,
    output logic                  o_value_ready,
    input  wire logic [WIDTH-1:0] i_value,
    output logic                  o_inverse_valid,
    input  wire logic             i_inverse_ready,
    output logic [WIDTH-1:0]      o_inverse,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [WIDTH-1:0] i_cfg_wr_data
);

    mie_pkg::t_cmd    cmd;
    mie_pkg::t_status status;

    // Sequencer
    mie_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_value_valid   (i_value_valid),
        .o_value_ready   (o_value_ready),
        .o_inverse_valid (o_inverse_valid),
        .i_inverse_ready (i_inverse_ready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    // Divider, multiply-mod and coefficient registers
    mie_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_value       (i_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_inverse     (o_inverse)
    );

endmodule

`default_nettype wire

/* rtl/core/mie_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module mie_datapath #(
    parameter int WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mie_pkg::t_cmd       i_cmd,
    output mie_pkg::t_status         o_status,
    input  wire logic [WIDTH-1:0]    i_value,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [WIDTH-1:0]    i_cfg_wr_data,
    output logic [WIDTH-1:0]         o_inverse
);

    localparam int XW = WIDTH + 3;

    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_dq;      // dividend, shifted out MSB first
    logic [WIDTH-1:0] r_rem;     // partial remainder
    logic [WIDTH-1:0] r_b;       // divisor of this round
    logic [WIDTH-1:0] r_u;
    logic [WIDTH-1:0] r_v;
    logic [WIDTH-1:0] r_acc;     // running q*v mod m
    logic [WIDTH-1:0] r_inverse;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH+1:0] rem_diff;
    logic             qbit;
    logic [WIDTH-1:0] n_rem;
    logic [XW-1:0]    dbl;
    logic [XW-1:0]    mx;
    logic [XW-1:0]    vx;
    logic [XW-1:0]    sum_v;
    logic [XW-1:0]    sum_v_m;
    logic [XW-1:0]    sum_v_2m;
    logic [XW-1:0]    dbl_m;
    logic [XW-1:0]    acc_sel;
    logic [WIDTH:0]   sub_d;
    logic [WIDTH-1:0] sub_w;
    logic [WIDTH-1:0] n_v;

    // Restoring division step: one quotient bit per cycle
    assign rem_sh   = {r_rem, r_dq[WIDTH-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, r_b};
    assign qbit     = ~rem_diff[WIDTH+1];
    assign n_rem    = qbit ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];

    // Horner step of q*v mod m, fed by the quotient bit; candidates in parallel
    assign dbl      = {2'b00, r_acc, 1'b0};
    assign mx       = {3'b000, r_mod};
    assign vx       = {3'b000, r_v};
    assign sum_v    = dbl + vx;
    assign sum_v_m  = dbl + vx - mx;
    assign sum_v_2m = dbl + vx - {mx[XW-2:0], 1'b0};
    assign dbl_m    = dbl - mx;

    always_comb begin
        if (qbit) begin
            if (!sum_v_2m[XW-1]) begin
                acc_sel = sum_v_2m;
            end else if (!sum_v_m[XW-1]) begin
                acc_sel = sum_v_m;
            end else begin
                acc_sel = sum_v;
            end
        end else begin
            acc_sel = dbl_m[XW-1] ? dbl : dbl_m;
        end
    end

    // New coefficient: (u - q*v) mod m
    assign sub_d = {1'b0, r_u} - {1'b0, r_acc};
    assign sub_w = sub_d[WIDTH-1:0] + r_mod;
    assign n_v   = sub_d[WIDTH] ? sub_w : sub_d[WIDTH-1:0];

    // Modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= mie_pkg::MODULUS_RESET[WIDTH-1:0];
        end else if (i_cfg_wr_en) begin
            r_mod <= i_cfg_wr_data;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dq  <= i_value;
            r_b   <= r_mod;
            r_rem <= '0;
            r_acc <= '0;
            r_u   <= {{(WIDTH-1){1'b0}}, (r_mod > {{(WIDTH-1){1'b0}}, 1'b1})};
            r_v   <= '0;
        end else if (i_cmd.div_step) begin
            r_dq  <= {r_dq[WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
            r_acc <= acc_sel[WIDTH-1:0];
        end else if (i_cmd.update) begin
            r_dq  <= r_b;
            r_b   <= r_rem;
            r_rem <= '0;
            r_acc <= '0;
            r_u   <= r_v;
            r_v   <= n_v;
        end
        if (i_cmd.store) begin
            r_inverse <= r_u;
        end
    end

    assign o_status.b_zero = (r_b == '0);
    assign o_inverse       = r_inverse;

endmodule

`default_nettype wire

/* rtl/core/mie_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module mie_ctrl #(
    parameter int WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_value_valid,
    output logic                     o_value_ready,
    output logic                     o_inverse_valid,
    input  wire logic                i_inverse_ready,
    input  wire mie_pkg::t_status    i_status,
    output mie_pkg::t_cmd            o_cmd
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    mie_pkg::t_state r_state;
    mie_pkg::t_state n_state;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_inverse_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mie_pkg::ST_IDLE: begin
                if (i_value_valid) n_state = mie_pkg::ST_CHECK;
            end
            mie_pkg::ST_CHECK: begin
                n_state = i_status.b_zero ? mie_pkg::ST_FINISH : mie_pkg::ST_DIV;
            end
            mie_pkg::ST_DIV: begin
                if (r_cnt == LAST) n_state = mie_pkg::ST_UPDATE;
            end
            mie_pkg::ST_UPDATE: begin
                n_state = mie_pkg::ST_CHECK;
            end
            mie_pkg::ST_FINISH: begin
                if (out_free) n_state = mie_pkg::ST_IDLE;
            end
            default: begin
                n_state = mie_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_value_ready   = 1'b0;
        o_cmd           = '0;
        case (r_state)
            mie_pkg::ST_IDLE: begin
                o_value_ready = 1'b1;
                o_cmd.load    = i_value_valid;
            end
            mie_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            mie_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            mie_pkg::ST_FINISH: begin
                o_cmd.store = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Bit counter and output slot
    assign n_cnt = (r_state == mie_pkg::ST_DIV) ? r_cnt + 1'b1 : '0;

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.store) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_inverse_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mie_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_inverse_valid = r_out_valid;

`ifndef SYNTHESIS
    // Division runs to its last bit before the round closes
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mie_pkg::ST_DIV) |=>
            (r_state == mie_pkg::ST_DIV) || (r_state == mie_pkg::ST_UPDATE))
        else $error("division left early");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mie_pkg::ST_DIV) && (r_cnt != LAST) |=>
            (r_state == mie_pkg::ST_DIV) && (r_cnt == $past(r_cnt) + 1'b1))
        else $error("bit counter out of step");

    a_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mie_pkg::ST_UPDATE) |=> (r_state == mie_pkg::ST_CHECK))
        else $error("round not rechecked");

    a_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.store |=> r_out_valid && (r_state == mie_pkg::ST_IDLE))
        else $error("stored result not presented");
`endif

endmodule

`default_nettype wire

/* tb/sv/modular_inverse_euclid_test.sv */
`timescale 1ns / 1ps

module modular_inverse_euclid_test;

    localparam int W = 32;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int NUM_DIRECTED = 23;
    localparam int NUM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 35;

    // One directed item: modulus in force, value, and a typed-in inverse when obvious
    typedef struct packed {
        logic [W-1:0] modulus;
        logic [W-1:0] value;
        logic         typed;
        logic [W-1:0] inverse;
    } t_vector;

    localparam t_vector DIRECTED_ROWS [NUM_DIRECTED] = '{
        // reset modulus
        '{32'd1000000007, 32'd0,          1'b1, 32'd0},
        '{32'd1000000007, 32'd1,          1'b1, 32'd1},
        '{32'd1000000007, 32'd1000000006, 1'b1, 32'd1000000006},
        '{32'd1000000007, 32'd1000000007, 1'b1, 32'd0},
        '{32'd1000000007, 32'd2,          1'b1, 32'd500000004},
        '{32'd1000000007, 32'hFFFF_FFFF,  1'b0, 32'd0},
        // largest modulus
        '{32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b1, 32'hFFFF_FFFE},
        '{32'hFFFF_FFFF,  32'd1,          1'b1, 32'd1},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd0},
        '{32'hFFFF_FFFF,  32'd2,          1'b1, 32'h8000_0000},
        '{32'hFFFF_FFFF,  32'd3,          1'b0, 32'd0},
        // smallest legal modulus
        '{32'd2,          32'd0,          1'b1, 32'd0},
        '{32'd2,          32'd1,          1'b1, 32'd1},
        '{32'd2,          32'hFFFF_FFFF,  1'b1, 32'd1},
        '{32'd2,          32'hFFFF_FFFE,  1'b1, 32'd0},
        // shared factor, then coprime
        '{32'd12,         32'd8,          1'b0, 32'd0},
        '{32'd12,         32'd5,          1'b1, 32'd5},
        // consecutive Fibonacci numbers: longest chain of rounds
        '{32'd2971215073, 32'd1836311903, 1'b0, 32'd0},
        '{32'd2971215073, 32'h5555_5555,  1'b0, 32'd0},
        // degenerate moduli always give zero
        '{32'd1,          32'hDEAD_BEEF,  1'b1, 32'd0},
        '{32'd1,          32'd0,          1'b1, 32'd0},
        '{32'd0,          32'd7,          1'b1, 32'd0},
        '{32'd0,          32'hFFFF_FFFF,  1'b1, 32'd0}
    };

    localparam logic [W-1:0] PRIMES [5] = '{
        32'd1000000007, 32'd998244353, 32'd4294967291, 32'd65521, 32'd251
    };

    logic         i_clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         value_valid = 1'b0;
    logic [W-1:0] value_data = '0;
    logic         inverse_ready = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [W-1:0] cfg_wr_data = '0;
    logic         o_value_ready;
    logic         o_inverse_valid;
    logic [W-1:0] o_inverse;

    logic [W-1:0] modulus_now = mie_pkg::MODULUS_RESET[W-1:0];
    logic [W-1:0] inverse_queue [$];
    logic [W-1:0] oldest_inverse;
    bit           steady = 1'b0;
    int           ready_hold = 0;
    int           fail_count = 0;
    int           checked_count = 0;
    int           sent_count = 0;
    int           settings_count = 0;
    int unsigned  cycle_count = 0;

    modular_inverse_euclid #(
        .WIDTH(W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_value_valid   (value_valid),
        .o_value_ready   (o_value_ready),
        .i_value         (value_data),
        .o_inverse_valid (o_inverse_valid),
        .i_inverse_ready (inverse_ready),
        .o_inverse       (o_inverse),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Extended Euclid with the coefficient pair kept reduced mod m
    function automatic logic [W-1:0] bezout_residue(input logic [W-1:0] val,
                                                    input logic [W-1:0] m);
        logic [63:0] rem_hi, rem_lo, quot, rem_next, coef_hi, coef_lo, prod, coef_next;
        if (m == '0)
            return '0;
        rem_hi  = 64'(val);
        rem_lo  = 64'(m);
        coef_hi = (m == 1) ? 64'd0 : 64'd1;
        coef_lo = 64'd0;
        while (rem_lo != 0) begin
            quot      = rem_hi / rem_lo;
            rem_next  = rem_hi - quot * rem_lo;
            rem_hi    = rem_lo;
            rem_lo    = rem_next;
            // quotient < 2^32 and coefficient < m, so the product fits 64 bits
            prod      = (quot * coef_lo) % 64'(m);
            coef_next = (coef_hi >= prod) ? coef_hi - prod : coef_hi + (64'(m) - prod);
            coef_hi   = coef_lo;
            coef_lo   = coef_next;
        end
        return coef_hi[W-1:0];
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [W-1:0] pick_modulus(input int kind);
        logic [W-1:0] m;
        case (kind)
            0: m = $urandom;
            1: m = $urandom_range(2, 1000);
            2: m = PRIMES[$urandom_range(0, 4)];
            3: m = $urandom | 32'h8000_0000;
            default: m = W'($urandom_range(1, 32767)) << 1;
        endcase
        if (m < 2)
            m = 2;
        return m;
    endfunction

    function automatic logic [W-1:0] pick_value(input logic [W-1:0] m);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5:       return (m == '0) ? W'($urandom) : W'($urandom_range(0, m - 1));
            6:          return $urandom_range(0, 20);
            7:          return m - 1;
            8:          return m * W'($urandom_range(1, 3));
            default:    return ~W'($urandom_range(0, 20));
        endcase
    endfunction

    // Present one item, predict on acceptance
    task automatic push_value(input logic [W-1:0] v, input logic typed,
                              input logic [W-1:0] inv);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            value_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        value_valid <= 1'b1;
        value_data  <= v;
        do @(posedge i_clk); while (!o_value_ready);
        inverse_queue.push_back(typed ? inv : bezout_residue(v, modulus_now));
        sent_count++;
        @(negedge i_clk);
    endtask

    // Modulus changes only with nothing in flight
    task automatic set_modulus(input logic [W-1:0] m);
        value_valid <= 1'b0;
        while (inverse_queue.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        modulus_now = m;
        settings_count++;
    endtask

    // Result side stalls
    always @(negedge i_clk) begin
        if (!rst_n || steady) begin
            ready_hold    <= 0;
            inverse_ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold    <= ready_hold - 1;
            inverse_ready <= 1'b0;
        end else begin
            ready_hold    <= pick_gap();
            inverse_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest pending inverse
    always @(posedge i_clk) begin
        if (rst_n && o_inverse_valid && inverse_ready) begin
            if (inverse_queue.size() == 0) begin
                $error("unexpected inverse item: %0d", o_inverse);
                fail_count++;
            end else begin
                oldest_inverse = inverse_queue.pop_front();
                if (o_inverse !== oldest_inverse) begin
                    $error("inverse mismatch: expected %0d, got %0d",
                           oldest_inverse, o_inverse);
                    fail_count++;
                end
                checked_count++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d inverses pending",
                     cycle_count, inverse_queue.size());
            $display("modular_inverse_euclid_test failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table
        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].modulus != modulus_now)
                set_modulus(DIRECTED_ROWS[i].modulus);
            push_value(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed,
                       DIRECTED_ROWS[i].inverse);
        end

        // Random phases, each under a new modulus; some run without stalls
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_modulus(pick_modulus(p % 5));
            steady = (p % 4 == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                push_value(pick_value(modulus_now), 1'b0, '0);
        end
        steady = 1'b0;

        // Drain
        value_valid <= 1'b0;
        while (inverse_queue.size() != 0) @(negedge i_clk);
        repeat (3 * (W + 2)) @(negedge i_clk);

        $display("sent %0d items (%0d from the table), checked %0d inverses",
                 sent_count, NUM_DIRECTED, checked_count);
        $display("used %0d modulus settings incl. 0, 1, 2 and 2^32-1; %0d cycles",
                 settings_count, cycle_count);
        if (fail_count == 0)
            $display("modular_inverse_euclid_test passed");
        else
            $display("modular_inverse_euclid_test failed");
        $finish;
    end

endmodule

/* modular_inverse_euclid.f */
rtl/core/mie_pkg.sv
rtl/core/mie_datapath.sv
rtl/core/mie_ctrl.sv
rtl/core/modular_inverse_euclid.sv
tb/sv/modular_inverse_euclid_test.sv
